[src/rpfa_pkg.sv]
// Shared types and constants for the refcounted page frame allocator.
package rpfa_pkg;

  localparam int FRAME_W  = 16;
  localparam int REG_W    = 17;
  localparam int OPC_W    = 3;
  localparam int STAT_W   = 3;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_INIT  = 3'd2,
    OP_INCR  = 3'd3,
    OP_DECR  = 3'd4,
    OP_GET   = 3'd5
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_OVER  = 3'd3,
    ST_UNDER = 3'd4,
    ST_FULL  = 3'd5
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FRAME = 1'b1;

endpackage

[src/rpfa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[src/refcounted_page_frame_allocator.sv]
// Page frame allocator: LIFO free stack, per-frame reference counts, free-frame count.
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_stall_o   opcode_i, frame_i
//   out      result     out_valid_o / out_stall_i status_o, alloc_frame_o, ref_count_o,
//                                                 free_count_o
//   cfg      write      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A request is handled in S_IDLE, where the transfer cycle issues the memory reads, and
// then in S_EXEC, which modifies and writes back the count and stack memories.
// After reset the count memory is cleared one entry a cycle through all NUM_FRAMES
// entries, with in_stall_o high; configuration writes are taken meanwhile.
// A result waiting on out_stall_i holds the following request in its write-back cycle.
module refcounted_page_frame_allocator #(
  parameter int NUM_FRAMES = 65536,
  parameter int COUNT_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rpfa_pkg::OPC_W-1:0]         opcode_i,
  input  logic [rpfa_pkg::FRAME_W-1:0]       frame_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rpfa_pkg::STAT_W-1:0]        status_o,
  output logic [rpfa_pkg::FRAME_W-1:0]       alloc_frame_o,
  output logic [COUNT_BITS-1:0]              ref_count_o,
  output logic [$clog2(NUM_FRAMES+1)-1:0]    free_count_o,
  input  logic                               cfg_we_i,
  input  logic [rpfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rpfa_pkg::REG_W-1:0]         cfg_wdata_i
);

  import rpfa_pkg::*;

  localparam int AW = $clog2(NUM_FRAMES);
  localparam int DW = $clog2(NUM_FRAMES + 1);
  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        clr_q;
  logic [DW-1:0]        depth_q, depth_d;
  logic [REG_W-1:0]     first_q, limit_q;
  opcode_e              op_q;
  logic [FRAME_W-1:0]   frame_q;
  logic                 inrange_q;
  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [FRAME_W-1:0]   alloc_q, alloc_d;
  logic [CW-1:0]        count_q, count_d;
  logic [DW-1:0]        fcount_q;

  logic                 in_accept, out_free, commit, inrange;

  logic                 ref_we, ref_we_x;
  logic [AW-1:0]        ref_waddr, ref_waddr_x;
  logic [CW-1:0]        ref_wdata, ref_wdata_x;
  logic [CW-1:0]        ref_rdata;
  logic                 stk_we_x;
  logic [FRAME_W-1:0]   stk_rdata;
  logic [CW-1:0]        nc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = (state_q == S_IDLE) && in_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign commit      = (state_q == S_EXEC) && out_free;

  assign inrange = ({1'b0, frame_i} >= first_q) && ({1'b0, frame_i} < limit_q) &&
                   (32'(frame_i) < 32'(NUM_FRAMES));

  // result and write-back for the request in flight
  always_comb begin
    status_d    = ST_OK;
    alloc_d     = '0;
    count_d     = '0;
    depth_d     = depth_q;
    ref_we_x    = 1'b0;
    ref_waddr_x = AW'(32'(frame_q));
    ref_wdata_x = '0;
    stk_we_x    = 1'b0;
    nc          = '0;
    unique case (op_q) inside
      OP_ALLOC: begin
        if (depth_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          ref_we_x    = 1'b1;
          ref_waddr_x = AW'(32'(stk_rdata));
          ref_wdata_x = CW'(1);
          depth_d     = depth_q - DW'(1);
          alloc_d     = stk_rdata;
          count_d     = CW'(1);
        end
      end
      OP_FREE, OP_INIT: begin
        if (!inrange_q) begin
          status_d = ST_RANGE;
        end else begin
          nc = (op_q == OP_INIT) ? '0 : ref_rdata;
          if (nc != '0) begin
            nc = nc - CW'(1);
          end
          if (nc == '0 && depth_q == DW'(NUM_FRAMES)) begin
            status_d = ST_FULL;
            count_d  = ref_rdata;
          end else begin
            ref_we_x    = 1'b1;
            ref_wdata_x = nc;
            count_d     = nc;
            if (nc == '0) begin
              stk_we_x = 1'b1;
              depth_d  = depth_q + DW'(1);
            end
          end
        end
      end
      OP_INCR: begin
        if (!inrange_q) begin
          status_d = ST_RANGE;
        end else if (ref_rdata == COUNT_MAX) begin
          status_d = ST_OVER;
          count_d  = ref_rdata;
        end else begin
          ref_we_x    = 1'b1;
          ref_wdata_x = ref_rdata + CW'(1);
          count_d     = ref_rdata + CW'(1);
        end
      end
      OP_DECR: begin
        if (!inrange_q) begin
          status_d = ST_RANGE;
        end else if (ref_rdata == '0) begin
          status_d = ST_UNDER;
        end else begin
          ref_we_x    = 1'b1;
          ref_wdata_x = ref_rdata - CW'(1);
          count_d     = ref_rdata - CW'(1);
        end
      end
      OP_GET: begin
        if (!inrange_q) begin
          status_d = ST_RANGE;
        end else begin
          count_d = ref_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // count memory write port: clearing pass or write-back
  always_comb begin
    if (state_q == S_CLEAR) begin
      ref_we    = 1'b1;
      ref_waddr = clr_q;
      ref_wdata = '0;
    end else begin
      ref_we    = commit && ref_we_x;
      ref_waddr = ref_waddr_x;
      ref_wdata = ref_wdata_x;
    end
  end

  rpfa_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_FRAMES)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .re_i    (in_accept),
    .raddr_i (AW'(32'(frame_i))),
    .rdata_o (ref_rdata)
  );

  rpfa_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (NUM_FRAMES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (commit && stk_we_x),
    .waddr_i (AW'(depth_q)),
    .wdata_i (frame_q),
    .re_i    (in_accept),
    .raddr_i (AW'(depth_q - DW'(1))),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      limit_q <= REG_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_FRAME: first_q <= cfg_wdata_i;
        CFG_LIMIT_FRAME: limit_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      depth_q     <= '0;
      op_q        <= OP_ALLOC;
      frame_q     <= '0;
      inrange_q   <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      alloc_q     <= '0;
      count_q     <= '0;
      fcount_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(NUM_FRAMES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            op_q      <= opcode_e'(opcode_i);
            frame_q   <= frame_i;
            inrange_q <= inrange;
            state_q   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            depth_q     <= depth_d;
            status_q    <= status_d;
            alloc_q     <= alloc_d;
            count_q     <= count_d;
            fcount_q    <= depth_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign alloc_frame_o = alloc_q;
  assign ref_count_o   = count_q;
  assign free_count_o  = fcount_q;

endmodule
